// File: hdl/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
package mexp_pkg;

  localparam int FIELD_W     = 32;
  localparam int DEF_WIDTH   = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = 2'd1;

endpackage

// File: hdl/modular_exponentiation.sv
// Top level of the modular exponentiation block with its sequencer and registers.
// Each base is raised to the exponent register modulo the modulus register by
// right-to-left square-and-multiply; a modulus of zero acts as one, and an exponent
// of zero gives 1. All arithmetic runs through one bit-serial modular multiplier:
// one product reduces the base, then the exponent is scanned from its low bit with
// a multiply for each set bit and a square between bits, the last square being
// skipped; a zero exponent needs only the reduction. A base is accepted only in
// the idle state, so one exponentiation runs at a time; the next base is taken
// while a result waits.
module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 base_valid,
  output logic                                 base_ready,
  input  logic [mexp_pkg::FIELD_W-1:0]         base,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [mexp_pkg::FIELD_W-1:0]         result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mexp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mexp_pkg::FIELD_W-1:0]         cfg_data
);

  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SQR    = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]               state;
  logic [2:0]               state_next;
  logic [WIDTH-1:0]         modulus;
  logic [WIDTH-1:0]         exponent;
  logic [WIDTH-1:0]         m_eff;
  logic [WIDTH-1:0]         e_sh;
  logic [WIDTH-1:0]         e_shr;
  logic [WIDTH-1:0]         r;
  logic [WIDTH-1:0]         p;
  logic [WIDTH+FIELD_W-1:0] cfg_ext;
  logic [WIDTH+FIELD_W-1:0] base_ext;
  logic [WIDTH+FIELD_W-1:0] r_ext;
  logic                     mm_start;
  logic [WIDTH-1:0]         mm_x;
  logic [WIDTH-1:0]         mm_y;
  logic                     mm_done;
  logic [WIDTH-1:0]         mm_product;
  logic                     base_xfer;

  assign cfg_ext    = {{WIDTH{1'b0}}, cfg_data};
  assign base_ext   = {{WIDTH{1'b0}}, base};
  assign r_ext      = {{FIELD_W{1'b0}}, r};
  assign m_eff      = (modulus == '0) ? WIDTH'(1) : modulus;
  assign e_shr      = {1'b0, e_sh[WIDTH-1:1]};
  assign cfg_ready  = 1'b1;
  assign base_ready = (state == ST_IDLE);
  assign base_xfer  = base_valid && base_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WIDTH'(1);
      exponent <= WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MODULUS) begin
        modulus <= cfg_ext[WIDTH-1:0];
      end else if (cfg_index == CFG_EXPONENT) begin
        exponent <= cfg_ext[WIDTH-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    mm_start   = 1'b0;
    mm_x       = r;
    mm_y       = mm_product;
    unique case (state)
      ST_IDLE: begin
        if (base_xfer) begin
          mm_start   = 1'b1;
          mm_x       = WIDTH'(1);
          mm_y       = base_ext[WIDTH-1:0];
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          if (e_sh == '0) begin
            state_next = ST_OUT;
          end else if (e_sh[0]) begin
            mm_start   = 1'b1;
            state_next = ST_MUL;
          end else begin
            mm_start   = 1'b1;
            mm_x       = mm_product;
            state_next = ST_SQR;
          end
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          if (e_shr == '0) begin
            state_next = ST_OUT;
          end else begin
            mm_start   = 1'b1;
            mm_x       = p;
            mm_y       = p;
            state_next = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          mm_start = 1'b1;
          if (e_shr[0]) begin
            state_next = ST_MUL;
          end else begin
            mm_x       = mm_product;
            state_next = ST_SQR;
          end
        end
      end
      ST_OUT: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (base_xfer) begin
      r    <= WIDTH'(1);
      e_sh <= exponent;
    end
    if (mm_done && state == ST_REDUCE) begin
      p <= mm_product;
    end
    if (mm_done && state == ST_MUL) begin
      r <= mm_product;
    end
    if (mm_done && state == ST_SQR) begin
      p    <= mm_product;
      e_sh <= e_shr;
    end
    if (state == ST_OUT && (!result_valid || result_ready)) begin
      result <= r_ext[FIELD_W-1:0];
    end
  end

  mexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .x       (mm_x),
    .y       (mm_y),
    .m       (m_eff),
    .done    (mm_done),
    .product (mm_product)
  );

  a_done_in_work: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == ST_REDUCE || state == ST_MUL || state == ST_SQR))
    else $error("Multiplier finished outside an exponentiation.");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    base_xfer |=> (state == ST_REDUCE))
    else $error("Accepted base did not start the reduction.");

  a_mul_on_set_bit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> e_sh[0])
    else $error("Multiply step taken for a clear exponent bit.");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && exponent != '0) |-> (r < m_eff))
    else $error("Final value is not reduced below the modulus.");

endmodule

// File: hdl/mexp_mulmod.sv
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module mexp_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] mr;
  logic [WIDTH:0]   sum_dbl;
  logic [WIDTH-1:0] red_dbl;
  logic [WIDTH:0]   sum_add;
  logic [WIDTH-1:0] red_add;
  logic [WIDTH-1:0] acc_next;

  always_comb begin
    sum_dbl = {1'b0, acc} + {1'b0, acc};
    if (sum_dbl >= {1'b0, mr}) begin
      red_dbl = sum_dbl[WIDTH-1:0] - mr;
    end else begin
      red_dbl = sum_dbl[WIDTH-1:0];
    end
    sum_add = {1'b0, red_dbl} + {1'b0, xr};
    if (sum_add >= {1'b0, mr}) begin
      red_add = sum_add[WIDTH-1:0] - mr;
    end else begin
      red_add = sum_add[WIDTH-1:0];
    end
    acc_next = yr[WIDTH-1] ? red_add : red_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      mr  <= m;
    end else if (busy) begin
      acc <= acc_next;
      yr  <= {yr[WIDTH-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule
